/* hw/rtl/lrpf_pkg.sv */
// lrpf_pkg: shared types, constants and the CRC-32 byte step for the log record page framer.
// Used by lrpf_front, lrpf_cmd_fifo, lrpf_back and log_record_page_framer_core.
package lrpf_pkg;

  localparam int PAGE_BYTES       = 4096;
  localparam int HDR_BYTES        = 7;
  localparam int MAX_RECORD_BYTES = 1048576;

  localparam int OFF_W   = 13;                          // page offset / fill level
  localparam int HO_W    = $clog2(PAGE_BYTES);          // header offset
  localparam int LEN_W   = 21;                          // record length
  localparam int PD_W    = 17;                          // pages per segment / pages done
  localparam int CODE_W  = 8;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int SPACE_W = 32;
  localparam int PROD_W  = 30;
  localparam int FIFO_DEPTH = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FULL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_MIDDLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LAST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_SEG   = 3'd4;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_PAD   = 2'd2,
    KIND_SEG   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    FRAG_NONE   = 3'd0,
    FRAG_FULL   = 3'd1,
    FRAG_FIRST  = 3'd2,
    FRAG_MIDDLE = 3'd3,
    FRAG_LAST   = 3'd4
  } frag_e;

  // result slots of one burst, in emission order
  localparam int SLOT_N = 11;
  localparam int SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SLOT_PREPAD = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_NEWSEG = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_TYPE   = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_LEN_HI = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_LEN_LO = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_DATA   = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_CRC0   = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_CRC1   = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_CRC2   = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_CRC3   = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_POST   = 4'd10;

  typedef struct packed {
    logic [SLOT_N-1:0] mask;      // which slots this transaction produces
    logic [OFF_W-1:0]  pad_off;
    logic [OFF_W-1:0]  hdr_off;
    logic [CODE_W-1:0] code;
    logic [OFF_W-1:0]  chunk;
    logic [OFF_W-1:0]  data_off;
    logic [7:0]        data;
    logic [31:0]       crc;
    kind_e             post_kind;
    logic [OFF_W-1:0]  post_off;
  } cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/lrpf_cmd_fifo.sv */
// lrpf_cmd_fifo: short command queue between the framer front and back.
// Depends on lrpf_pkg (cmd_t, FIFO_DEPTH).
module lrpf_cmd_fifo
  import lrpf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (PTR_W+1)'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

endmodule

/* hw/rtl/lrpf_front.sv */
// lrpf_front: configuration registers, framing state and per-byte classification.
// Depends on lrpf_pkg; pushes one cmd_t per producing transaction.
module lrpf_front
  import lrpf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_data_byte_i,
  input  logic                 in_first_of_record_i,
  input  logic [LEN_W-1:0]     in_record_length_i,
  input  logic                 in_flush_each_chunk_i,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  logic [CODE_W-1:0] code_full_q, code_first_q, code_middle_q, code_last_q;
  logic [PD_W-1:0]   pps_q;

  logic [OFF_W-1:0]  pf_q, pf_d;
  logic [PD_W-1:0]   pd_q, pd_d;
  logic [LEN_W-1:0]  rl_q, rl_d;
  logic [OFF_W-1:0]  cl_q, cl_d;
  frag_e             ft_q, ft_d;
  logic [HO_W-1:0]   ho_q, ho_d;
  logic [31:0]       crc_q, crc_d;
  logic              fm_q, fm_d;

  // segment space, recomputed in the cycle after any state change
  logic [SPACE_W-1:0] space_q;
  logic               full_q;
  logic               space_ok_q;
  logic [PD_W-1:0]    pages_rest;
  logic [PROD_W-1:0]  prod;

  logic              take;
  logic [LEN_W-1:0]  len_c, rl0;
  logic              roll, open, tiny, frag_end;
  logic [OFF_W-1:0]  pf0, pf1, pf2, pf3, room, chunk, cl0, cl1;
  logic [PD_W-1:0]   pd0, pd1;
  frag_e             ft0, ft1;
  logic              fm0;
  logic [31:0]       crc0, crc1;
  logic [CODE_W-1:0] code;
  logic [HO_W-1:0]   ho1;

  assign pages_rest = pps_q - pd_q - PD_W'(1);
  assign prod = PROD_W'(pages_rest) * PROD_W'(PAGE_BYTES - HDR_BYTES);

  assign in_ready_o = !fifo_full_i && (!in_first_of_record_i || space_ok_q);
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    pf_d = pf_q; pd_d = pd_q; rl_d = rl_q; cl_d = cl_q;
    ft_d = ft_q; ho_d = ho_q; crc_d = crc_q; fm_d = fm_q;
    push_o = 1'b0;
    cmd_o = '0;
    cmd_o.post_kind = KIND_WRITE;

    len_c = (in_record_length_i > LEN_W'(MAX_RECORD_BYTES)) ?
            LEN_W'(MAX_RECORD_BYTES) : in_record_length_i;
    roll = in_first_of_record_i && (full_q || (space_q < SPACE_W'(len_c)));

    pf0 = roll ? '0 : pf_q;
    pd0 = roll ? '0 : pd_q;
    rl0 = in_first_of_record_i ? len_c : rl_q;
    cl0 = in_first_of_record_i ? '0 : cl_q;
    ft0 = in_first_of_record_i ? FRAG_NONE : ft_q;
    fm0 = in_first_of_record_i ? in_flush_each_chunk_i : fm_q;

    open = (cl0 == '0);
    tiny = open && (pf0 >= OFF_W'(PAGE_BYTES - HDR_BYTES));
    pf1  = tiny ? '0 : pf0;
    pd1  = (tiny && pd0 != '1) ? pd0 + 1'b1 : pd0;
    room = OFF_W'(PAGE_BYTES - HDR_BYTES) - pf1;
    chunk = (rl0 < LEN_W'(room)) ? rl0[OFF_W-1:0] : room;

    ft1 = ft0;
    if (open) begin
      if (ft0 == FRAG_NONE) ft1 = (LEN_W'(chunk) == rl0) ? FRAG_FULL : FRAG_FIRST;
      else                  ft1 = (LEN_W'(chunk) == rl0) ? FRAG_LAST : FRAG_MIDDLE;
    end
    unique case (ft1)
      FRAG_FULL:   code = code_full_q;
      FRAG_FIRST:  code = code_first_q;
      FRAG_MIDDLE: code = code_middle_q;
      default:     code = code_last_q;
    endcase

    ho1  = open ? pf1[HO_W-1:0] : ho_q;
    pf2  = open ? pf1 + OFF_W'(HDR_BYTES) : pf1;
    pf3  = pf2 + 1'b1;
    crc0 = open ? '1 : crc_q;
    crc1 = crc_byte(crc0, in_data_byte_i);
    cl1  = (open ? chunk : cl0) - 1'b1;
    frag_end = (cl1 == '0);

    if (take) begin
      if (in_first_of_record_i && in_record_length_i == '0) begin
        rl_d = '0;
        cl_d = '0;
      end else if (in_first_of_record_i || rl_q != '0) begin
        push_o = 1'b1;
        cmd_o.mask[SLOT_PREPAD] = (roll && pf_q != '0) || tiny;
        cmd_o.mask[SLOT_NEWSEG] = roll;
        cmd_o.mask[SLOT_TYPE]   = open;
        cmd_o.mask[SLOT_LEN_HI] = open;
        cmd_o.mask[SLOT_LEN_LO] = open;
        cmd_o.mask[SLOT_DATA]   = 1'b1;
        cmd_o.mask[SLOT_CRC0]   = frag_end;
        cmd_o.mask[SLOT_CRC1]   = frag_end;
        cmd_o.mask[SLOT_CRC2]   = frag_end;
        cmd_o.mask[SLOT_CRC3]   = frag_end;
        cmd_o.pad_off  = roll ? pf_q : pf0;
        cmd_o.hdr_off  = OFF_W'(ho1);
        cmd_o.code     = code;
        cmd_o.chunk    = chunk;
        cmd_o.data_off = pf2;
        cmd_o.data     = in_data_byte_i;
        cmd_o.crc      = ~crc1;
        cmd_o.post_off = pf3;

        pf_d = pf3; pd_d = pd1;
        rl_d = rl0 - 1'b1;
        cl_d = cl1;
        ft_d = ft1;
        ho_d = ho1;
        crc_d = crc1;
        fm_d = fm0;
        if (frag_end) begin
          if (pf3 >= OFF_W'(PAGE_BYTES - HDR_BYTES)) begin
            cmd_o.mask[SLOT_POST] = 1'b1;
            cmd_o.post_kind = KIND_PAD;
            pf_d = '0;
            if (pd1 != '1) pd_d = pd1 + 1'b1;
          end else if (fm0) begin
            cmd_o.mask[SLOT_POST] = 1'b1;
            cmd_o.post_kind = KIND_FLUSH;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_full_q   <= CODE_W'(1);
      code_first_q  <= CODE_W'(2);
      code_middle_q <= CODE_W'(3);
      code_last_q   <= CODE_W'(4);
      pps_q         <= PD_W'(8192);
      pf_q  <= '0; pd_q <= '0; rl_q <= '0; cl_q <= '0;
      ft_q  <= FRAG_NONE; ho_q <= '0; crc_q <= '1; fm_q <= 1'b0;
      space_q    <= '0;
      full_q     <= 1'b0;
      space_ok_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CODE_FULL:   code_full_q   <= cfg_data_i[CODE_W-1:0];
          CFG_CODE_FIRST:  code_first_q  <= cfg_data_i[CODE_W-1:0];
          CFG_CODE_MIDDLE: code_middle_q <= cfg_data_i[CODE_W-1:0];
          CFG_CODE_LAST:   code_last_q   <= cfg_data_i[CODE_W-1:0];
          CFG_PAGES_SEG:   pps_q         <= cfg_data_i[PD_W-1:0];
          default: ;
        endcase
      end
      pf_q <= pf_d; pd_q <= pd_d; rl_q <= rl_d; cl_q <= cl_d;
      ft_q <= ft_d; ho_q <= ho_d; crc_q <= crc_d; fm_q <= fm_d;
      space_q    <= SPACE_W'(PAGE_BYTES) - SPACE_W'(pf_q) + SPACE_W'(prod);
      full_q     <= (pd_q >= pps_q);
      space_ok_q <= !(take || cfg_we_i);
    end
  end

endmodule

/* hw/rtl/lrpf_back.sv */
// lrpf_back: expands queued commands into one result per cycle behind an output register, stalled by out_ready_i.
// Depends on lrpf_pkg (cmd_t, slot codes, kind_e).
module lrpf_back
  import lrpf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cmd_t             q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kind_e            out_kind_o,
  output logic [OFF_W-1:0] out_page_offset_o,
  output logic [7:0]       out_byte_value_o,
  output logic             out_last_of_burst_o
);

  cmd_t              cmd_q;
  logic [SLOT_N-1:0] mask_q, mask_d;
  logic              active_q;
  logic              out_valid_q;
  kind_e             kind_q, kind_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [7:0]        val_q, val_d;
  logic              last_q;

  logic [SLOT_W-1:0] slot;
  logic              emit, single, load;

  always_comb begin
    slot = SLOT_POST;
    for (int i = SLOT_N - 1; i >= 0; i--) begin
      if (mask_q[i]) slot = SLOT_W'(i);
    end
  end

  assign single = ($countones(mask_q) == 1);
  assign emit   = active_q && (!out_valid_q || out_ready_i);
  assign load   = q_valid_i && (!active_q || (emit && single));
  assign q_pop_o = load;

  always_comb begin
    mask_d = mask_q;
    mask_d[slot] = 1'b0;
    kind_d = KIND_WRITE;
    off_d  = '0;
    val_d  = '0;
    unique case (slot)
      SLOT_PREPAD: begin kind_d = KIND_PAD; off_d = cmd_q.pad_off; end
      SLOT_NEWSEG: kind_d = KIND_SEG;
      SLOT_TYPE:   begin off_d = cmd_q.hdr_off; val_d = cmd_q.code; end
      SLOT_LEN_HI: begin
        off_d = cmd_q.hdr_off + OFF_W'(1);
        val_d = 8'(cmd_q.chunk >> 8);
      end
      SLOT_LEN_LO: begin off_d = cmd_q.hdr_off + OFF_W'(2); val_d = cmd_q.chunk[7:0]; end
      SLOT_DATA:   begin off_d = cmd_q.data_off; val_d = cmd_q.data; end
      SLOT_CRC0:   begin off_d = cmd_q.hdr_off + OFF_W'(3); val_d = cmd_q.crc[7:0]; end
      SLOT_CRC1:   begin off_d = cmd_q.hdr_off + OFF_W'(4); val_d = cmd_q.crc[15:8]; end
      SLOT_CRC2:   begin off_d = cmd_q.hdr_off + OFF_W'(5); val_d = cmd_q.crc[23:16]; end
      SLOT_CRC3:   begin off_d = cmd_q.hdr_off + OFF_W'(6); val_d = cmd_q.crc[31:24]; end
      default:     begin kind_d = cmd_q.post_kind; off_d = cmd_q.post_off; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) cmd_q <= q_cmd_i;
    if (emit) begin
      kind_q <= kind_d;
      off_q  <= off_d;
      val_q  <= val_d;
      last_q <= single;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (load) begin
        active_q <= 1'b1;
        mask_q   <= q_cmd_i.mask;
      end else if (emit) begin
        mask_q <= mask_d;
        if (single) active_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_kind_o          = kind_q;
  assign out_page_offset_o   = off_q;
  assign out_byte_value_o    = val_q;
  assign out_last_of_burst_o = last_q;

  a_active_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> mask_q != '0) else $error("active burst with no slots left");

  a_seg_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_SEG |-> off_q == '0)
    else $error("new segment event with nonzero offset");

  a_burst_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && single && !q_valid_i |=> !active_q && out_last_of_burst_o)
    else $error("burst did not close after its last slot");

endmodule

/* hw/rtl/log_record_page_framer_core.sv */
// log_record_page_framer_core: top level of the log record page framer.
// Depends on lrpf_pkg, lrpf_front, lrpf_cmd_fifo and lrpf_back.
//
// Takes log record bytes one per transaction (length with the first byte), cuts each
// record into page fragments with a 7-byte header (type, big-endian length, little-endian
// CRC-32 written back at fragment end) and emits page-offset byte writes plus flush, page
// pad and new-segment events, one result per transaction on the output. The front takes a
// payload byte every cycle while the command queue has room; a first-of-record byte needs
// the segment space figure, which is a registered multiply of the state, so it is held off
// after any accepted byte or configuration write until that figure is recomputed. Each
// byte yields up to 11 results (none for a stray or zero-length byte) and the back drains
// one per cycle while the receiver is ready, so sustained input rate is set by the result
// count per byte, with a 4-entry command queue absorbing header and CRC bursts.
// Configuration writes are taken at any edge with cfg_we_i high; write only while idle.
module log_record_page_framer_core
  import lrpf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_data_byte_i,
  input  logic                 in_first_of_record_i,
  input  logic [LEN_W-1:0]     in_record_length_i,
  input  logic                 in_flush_each_chunk_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_kind_o,
  output logic [OFF_W-1:0]     out_page_offset_o,
  output logic [7:0]           out_byte_value_o,
  output logic                 out_last_of_burst_o
);

  logic  fifo_full, push, q_valid, q_pop;
  cmd_t  push_cmd, q_cmd;
  kind_e out_kind;

  lrpf_front u_front (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .in_data_byte_i, .in_first_of_record_i, .in_record_length_i, .in_flush_each_chunk_i,
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  lrpf_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  lrpf_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i           (q_valid),
    .q_cmd_i             (q_cmd),
    .q_pop_o             (q_pop),
    .out_valid_o,
    .out_ready_i,
    .out_kind_o          (out_kind),
    .out_page_offset_o,
    .out_byte_value_o,
    .out_last_of_burst_o
  );

  assign out_kind_o = out_kind;

endmodule

/* tb/sv/lrpf_checker.sv */
// lrpf_checker: watches the configuration port and both channels of the page framer,
// predicts the result transactions of every accepted input byte and compares them in order.
// Depends on lrpf_pkg for widths, register indexes and the kind and fragment enums.
module lrpf_checker
  import lrpf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [7:0]           in_data_byte_i,
  input  logic                 in_first_of_record_i,
  input  logic [LEN_W-1:0]     in_record_length_i,
  input  logic                 in_flush_each_chunk_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           out_kind_i,
  input  logic [OFF_W-1:0]     out_page_offset_i,
  input  logic [7:0]           out_byte_value_i,
  input  logic                 out_last_of_burst_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    kind_e            kind;
    logic [OFF_W-1:0] offset;
    logic [7:0]       value;
    logic             last;
  } page_op_t;

  page_op_t page_op_q[$];

  // configuration copy
  logic [7:0]  code_full, code_first, code_middle, code_last;
  int unsigned seg_pages;

  // framer state copy
  int unsigned fill, pages_done, rec_left, chunk_left, hdr_off, frag_crc;
  frag_e       frag;
  logic        flush_mode;
  int          burst_n;

  assign pending_o = page_op_q.size();

  task automatic queue_op(kind_e k, int unsigned off, logic [7:0] v);
    page_op_t op;
    op.kind   = k;
    op.offset = off[OFF_W-1:0];
    op.value  = v;
    op.last   = 1'b0;
    page_op_q.insert(page_op_q.size(), op);
    burst_n++;
  endtask

  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++)
      r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    return r;
  endfunction

  task automatic pad_page();
    queue_op(KIND_PAD, fill, 8'd0);
    fill = 0;
    if (pages_done < 131071) pages_done++;
  endtask

  task automatic start_fragment();
    int unsigned room, chunk;
    logic [7:0]  code;
    if (PAGE_BYTES - fill <= HDR_BYTES) pad_page();
    room  = PAGE_BYTES - fill - HDR_BYTES;
    chunk = (rec_left < room) ? rec_left : room;
    if (frag == FRAG_NONE) frag = (chunk == rec_left) ? FRAG_FULL : FRAG_FIRST;
    else                   frag = (chunk == rec_left) ? FRAG_LAST : FRAG_MIDDLE;
    case (frag)
      FRAG_FULL:   code = code_full;
      FRAG_FIRST:  code = code_first;
      FRAG_MIDDLE: code = code_middle;
      default:     code = code_last;
    endcase
    hdr_off = fill;
    queue_op(KIND_WRITE, fill, code);
    queue_op(KIND_WRITE, fill + 1, chunk[15:8]);
    queue_op(KIND_WRITE, fill + 2, chunk[7:0]);
    fill      += HDR_BYTES;
    frag_crc   = 32'hFFFFFFFF;
    chunk_left = chunk;
  endtask

  // expected page operations of one accepted input byte
  task automatic frame_byte(logic [7:0] data, logic first, int unsigned len, logic flush);
    longint unsigned space;
    logic [31:0]     crc;
    burst_n = 0;
    if (first) begin
      if (len == 0) begin
        rec_left   = 0;
        chunk_left = 0;
        return;
      end
      if (len > MAX_RECORD_BYTES) len = MAX_RECORD_BYTES;
      if (pages_done >= seg_pages) space = 0;
      else space = longint'(PAGE_BYTES - fill) +
                   longint'(PAGE_BYTES - HDR_BYTES) * longint'(seg_pages - pages_done - 1);
      // record does not fit: close the page and roll over to a new segment
      if (space < len) begin
        if (fill > 0) pad_page();
        queue_op(KIND_SEG, 0, 8'd0);
        fill       = 0;
        pages_done = 0;
      end
      rec_left   = len;
      chunk_left = 0;
      frag       = FRAG_NONE;
      flush_mode = flush;
    end else if (rec_left == 0) begin
      return;  // stray byte
    end
    if (chunk_left == 0) start_fragment();
    queue_op(KIND_WRITE, fill, data);
    fill++;
    frag_crc = crc32_step(frag_crc, data);
    chunk_left--;
    rec_left--;
    if (chunk_left == 0) begin
      crc = ~frag_crc;
      for (int i = 0; i < 4; i++) queue_op(KIND_WRITE, hdr_off + 3 + i, crc[8*i +: 8]);
      if (PAGE_BYTES <= fill + HDR_BYTES) pad_page();
      else if (flush_mode) queue_op(KIND_FLUSH, fill, 8'd0);
    end
    if (burst_n > 0) page_op_q[page_op_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    page_op_t exp_op;
    if (!rst_ni) begin
      page_op_q.delete();
      fail_count_o <= 0;
      code_full   = 8'd1;
      code_first  = 8'd2;
      code_middle = 8'd3;
      code_last   = 8'd4;
      seg_pages   = 8192;
      fill = 0; pages_done = 0; rec_left = 0; chunk_left = 0; hdr_off = 0;
      frag = FRAG_NONE; frag_crc = 32'hFFFFFFFF; flush_mode = 1'b0;
    end else begin
      // results first: a byte accepted now cannot have results out at this edge
      if (out_valid_i && out_ready_i) begin
        if (page_op_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d offset %0d value %0h", $time,
                   out_kind_i, out_page_offset_i, out_byte_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_op = page_op_q.pop_front();
          if (out_kind_i !== exp_op.kind || out_page_offset_i !== exp_op.offset ||
              out_byte_value_i !== exp_op.value || out_last_of_burst_i !== exp_op.last) begin
            $display("%0t: mismatch expected kind %0d off %0d val %0h last %0b", $time,
                     exp_op.kind, exp_op.offset, exp_op.value, exp_op.last);
            $display("%0t:            actual kind %0d off %0d val %0h last %0b", $time,
                     out_kind_i, out_page_offset_i, out_byte_value_i, out_last_of_burst_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CODE_FULL:   code_full   = cfg_data_i[7:0];
          CFG_CODE_FIRST:  code_first  = cfg_data_i[7:0];
          CFG_CODE_MIDDLE: code_middle = cfg_data_i[7:0];
          CFG_CODE_LAST:   code_last   = cfg_data_i[7:0];
          CFG_PAGES_SEG:   seg_pages   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        frame_byte(in_data_byte_i, in_first_of_record_i, in_record_length_i,
                   in_flush_each_chunk_i);
    end
  end

endmodule

/* tb/sv/testbench.sv */
// testbench: stimulus and verdict for log_record_page_framer_core.
// Depends on lrpf_pkg, the framer RTL and lrpf_checker, which does all prediction and checks.
module testbench;
  import lrpf_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           in_data_byte_i;
  logic                 in_first_of_record_i;
  logic [LEN_W-1:0]     in_record_length_i;
  logic                 in_flush_each_chunk_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [1:0]           out_kind_o;
  logic [OFF_W-1:0]     out_page_offset_o;
  logic [7:0]           out_byte_value_o;
  logic                 out_last_of_burst_o;
  int                   fail_count;
  int                   pending;

  // no random idling in the closing phase
  logic quiet;
  int   rx_stall;
  int   byte_count;

  log_record_page_framer_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_byte_i, .in_first_of_record_i,
    .in_record_length_i, .in_flush_each_chunk_i,
    .out_valid_o, .out_ready_i, .out_kind_o, .out_page_offset_o,
    .out_byte_value_o, .out_last_of_burst_o
  );

  lrpf_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_byte_i, .in_first_of_record_i,
    .in_record_length_i, .in_flush_each_chunk_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_kind_i(out_kind_o),
    .out_page_offset_i(out_page_offset_o), .out_byte_value_i(out_byte_value_o),
    .out_last_of_burst_i(out_last_of_burst_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // receiver: stalls come in bursts of random length
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall    <= 0;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (rx_stall > 0) begin
      out_ready_i <= 1'b0;
      rx_stall    <= rx_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      rx_stall    <= $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // one input transaction; valid stays up after acceptance unless an idle burst follows
  task automatic put_byte(logic [7:0] data, logic first, logic [LEN_W-1:0] len, logic flush);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_data_byte_i        <= data;
    in_first_of_record_i  <= first;
    in_record_length_i    <= len;
    in_flush_each_chunk_i <= flush;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    byte_count++;
  endtask

  // a record of len bytes of which only n are sent; n < len leaves it unfinished
  task automatic put_record(int unsigned len, logic flush, int unsigned n);
    put_byte(8'($urandom), 1'b1, LEN_W'(len), flush);
    for (int unsigned i = 1; i < n; i++)
      put_byte(8'($urandom), 1'b0, LEN_W'($urandom), 1'($urandom));
  endtask

  // drain: valid low, wait for every expected result, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [7:0] full, logic [7:0] first, logic [7:0] middle,
                            logic [7:0] last, logic [CFG_W-1:0] pages);
    logic [CFG_W-1:0] vals[5];
    vals = '{{9'd0, full}, {9'd0, first}, {9'd0, middle}, {9'd0, last}, pages};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned len;
    rst_ni                = 1'b0;
    quiet                 = 1'b0;
    byte_count            = 0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_CODE_FULL;
    cfg_data_i            = '0;
    in_valid_i            = 1'b0;
    in_data_byte_i        = '0;
    in_first_of_record_i  = 1'b0;
    in_record_length_i    = '0;
    in_flush_each_chunk_i = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: stray byte, zero length, tiny records, clamped overlong record abandoned
    put_byte(8'hFF, 1'b0, 21'h1FFFFF, 1'b1);
    put_byte(8'h00, 1'b1, 21'd0, 1'b1);
    put_byte(8'h00, 1'b1, 21'd1, 1'b1);
    put_byte(8'hFF, 1'b1, 21'd2, 1'b0);
    put_byte(8'hA5, 1'b0, 21'd0, 1'b0);
    put_record(32'h1FFFFF, 1'b1, 3);
    put_record(3, 1'b0, 3);
    put_byte(8'h3C, 1'b0, 21'd7, 1'b1);

    // random small records, some abandoned, with stray and zero-length bytes between
    while (byte_count < 100) begin
      case ($urandom_range(0, 19))
        0: put_byte(8'($urandom), 1'b0, LEN_W'($urandom), 1'($urandom));
        1: put_byte(8'($urandom), 1'b1, 21'd0, 1'($urandom));
        2, 3: begin
          len = $urandom_range(2, 24);
          put_record(len, 1'($urandom), $urandom_range(1, len - 1));
        end
        default: begin
          len = $urandom_range(1, 24);
          put_record(len, 1'($urandom), len);
        end
      endcase
    end
    drain();

    // two-page segment: long records, cut short, do not fit and force a new segment
    write_regs(8'h5A, 8'hA5, 8'h0F, 8'hF0, 17'd2);
    for (int r = 0; r < 12; r++) begin
      if ($urandom_range(0, 2) == 0) begin
        put_record($urandom_range(9000, 20000), 1'($urandom), $urandom_range(1, 3));
      end else begin
        len = $urandom_range(1, 6);
        put_record(len, 1'($urandom), len);
      end
    end
    drain();

    // 65536-page segment, no idling on either side
    write_regs(8'h80, 8'h7F, 8'h01, 8'hFE, 17'd65536);
    quiet = 1'b1;
    for (int r = 0; r < 8; r++) begin
      len = $urandom_range(1, 6);
      put_record(len, 1'($urandom), len);
    end
    drain();

    if (fail_count == 0 && pending == 0)
      $display("log_record_page_framer_core verification clean");
    else
      $display("log_record_page_framer_core verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("log_record_page_framer_core verification failed");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lrpf_pkg.sv
hw/rtl/lrpf_cmd_fifo.sv
hw/rtl/lrpf_front.sv
hw/rtl/lrpf_back.sv
hw/rtl/log_record_page_framer_core.sv
tb/sv/lrpf_checker.sv
tb/sv/testbench.sv
